// File: rtl/bcp_pkg.sv
// Shared types and constants for the box collision pushback block.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none

package bcp_pkg;

    // Item operation codes.
    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_MOVE_X  = 2'd1,
        OP_MOVE_Y  = 2'd2,
        OP_RESET   = 2'd3
    } t_op;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_OBJECT_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_OBJECT_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_SPEED_X       = 3'd2;
    localparam t_cfg_idx CFG_SPEED_Y       = 3'd3;
    localparam t_cfg_idx CFG_RECT_COUNT    = 3'd4;

    // Field widths.
    localparam int POS_W   = 16;
    localparam int SIZE_W  = 12;
    localparam int SPEED_W = 11;
    localparam int COUNT_W = 5;
    localparam int SLOT_W  = 4;
    localparam int CFG_W   = 12;

    // One obstacle rectangle as kept in the table.
    typedef struct packed {
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] right;
        logic signed [POS_W-1:0] top;
        logic signed [POS_W-1:0] bottom;
    } t_rect;

endpackage

`default_nettype wire

// File: rtl/box_collision_pushback_unit.sv
// Box collision pushback top level: sequencer, position and configuration.
// Depends on bcp_pkg, bcp_rect_mem and bcp_overlap_unit.
// A load or reset-position word goes from S_IDLE straight to S_DONE; a move
// word goes through S_ADD, S_SCAN and S_DONE. S_SCAN reads the table one
// rectangle per cycle, for rect_count entries limited to MAX_RECTS, through
// a single registered memory port into one shared overlap comparator. The
// result word appears on the o_ ports for one cycle with o_strobe high and
// must be taken then, since the receiver cannot stall; busy stays high after
// an accepted word through that cycle. There is no clearing pass after reset.
`default_nettype none

module box_collision_pushback_unit #(
    parameter int MAX_RECTS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Command side
    input  wire                                  start,
    output logic                                 busy,
    input  wire        [1:0]                     i_operation,
    input  wire        [bcp_pkg::SLOT_W-1:0]     i_rect_index,
    input  wire signed [bcp_pkg::POS_W-1:0]      i_rect_left,
    input  wire signed [bcp_pkg::POS_W-1:0]      i_rect_right,
    input  wire signed [bcp_pkg::POS_W-1:0]      i_rect_top,
    input  wire signed [bcp_pkg::POS_W-1:0]      i_rect_bottom,
    input  wire                                  i_move_dir,
    // Configuration write port
    input  wire                                  i_cfg_we,
    input  wire        [bcp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire        [bcp_pkg::CFG_W-1:0]      i_cfg_data,
    // Result side
    output logic                                 o_strobe,
    output logic signed [bcp_pkg::POS_W-1:0]     o_pos_x_out,
    output logic signed [bcp_pkg::POS_W-1:0]     o_pos_y_out,
    output logic                                 o_hit
);
    import bcp_pkg::*;

    localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int LIM_W = $clog2(MAX_RECTS + 1);
    localparam int CMP_W = (LIM_W > COUNT_W) ? LIM_W : COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [SIZE_W-1:0]  r_obj_w;
    logic [SIZE_W-1:0]  r_obj_h;
    logic [SPEED_W-1:0] r_speed_x;
    logic [SPEED_W-1:0] r_speed_y;
    logic [COUNT_W-1:0] r_rect_count;

    // Working registers
    t_op                r_op;
    logic               r_dir;
    logic               r_fin;
    logic signed [POS_W-1:0] r_pos_x;
    logic signed [POS_W-1:0] r_pos_y;
    logic [LIM_W-1:0]   r_limit;
    logic [LIM_W-1:0]   r_issue;
    logic               r_pend;
    logic               r_found;
    logic signed [POS_W-1:0] r_edge_near;
    logic signed [POS_W-1:0] r_edge_far;
    logic               r_hit;

    logic               accept;
    logic               load_we;
    t_rect              wr_rect;
    t_rect              rd_rect;
    logic [IDX_W-1:0]   rd_addr;
    logic               overlap;
    logic [LIM_W-1:0]   limit_calc;
    logic               axis_x;
    logic [SIZE_W-1:0]  axis_size;
    logic signed [POS_W-1:0] push_pos;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign axis_x  = (r_op == OP_MOVE_X);
    assign load_we = accept && (t_op'(i_operation) == OP_LOAD) &&
                     (32'(i_rect_index) < MAX_RECTS);

    assign wr_rect.left   = i_rect_left;
    assign wr_rect.right  = i_rect_right;
    assign wr_rect.top    = i_rect_top;
    assign wr_rect.bottom = i_rect_bottom;
    assign rd_addr        = r_issue[IDX_W-1:0];

    // Active count, saturated at the table depth.
    always_comb begin
        if (CMP_W'(r_rect_count) > CMP_W'(MAX_RECTS)) begin
            limit_calc = LIM_W'(MAX_RECTS);
        end else begin
            limit_calc = LIM_W'(r_rect_count);
        end
    end

    // Pushback target for the moved axis.
    always_comb begin
        axis_size = axis_x ? r_obj_w : r_obj_h;
        if (r_dir) begin
            push_pos = r_edge_far;
        end else begin
            push_pos = r_edge_near - $signed({{(POS_W-SIZE_W){1'b0}}, axis_size});
        end
    end

    bcp_rect_mem #(
        .DEPTH (MAX_RECTS),
        .AW    (IDX_W)
    ) u_rect_mem (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (IDX_W'(i_rect_index)),
        .i_wdata (wr_rect),
        .i_raddr (rd_addr),
        .o_rdata (rd_rect)
    );

    bcp_overlap_unit u_overlap (
        .i_pos_x   (r_pos_x),
        .i_pos_y   (r_pos_y),
        .i_width   (r_obj_w),
        .i_height  (r_obj_h),
        .i_rect    (rd_rect),
        .o_overlap (overlap)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_w      <= '0;
            r_obj_h      <= '0;
            r_speed_x    <= '0;
            r_speed_y    <= '0;
            r_rect_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OBJECT_WIDTH:  r_obj_w      <= i_cfg_data[SIZE_W-1:0];
                CFG_OBJECT_HEIGHT: r_obj_h      <= i_cfg_data[SIZE_W-1:0];
                CFG_SPEED_X:       r_speed_x    <= i_cfg_data[SPEED_W-1:0];
                CFG_SPEED_Y:       r_speed_y    <= i_cfg_data[SPEED_W-1:0];
                CFG_RECT_COUNT:    r_rect_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_op'(i_operation) == OP_MOVE_X ||
                        t_op'(i_operation) == OP_MOVE_Y) begin
                        n_state = S_ADD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ADD: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_fin) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Position, scan counter and hit tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_hit   <= 1'b0;
            r_found <= 1'b0;
            r_pend  <= 1'b0;
            r_fin   <= 1'b0;
            r_issue <= '0;
            r_limit <= '0;
            r_op    <= OP_LOAD;
            r_dir   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op  <= t_op'(i_operation);
                        r_dir <= i_move_dir;
                        r_hit <= 1'b0;
                        if (t_op'(i_operation) == OP_RESET) begin
                            r_pos_x <= '0;
                            r_pos_y <= '0;
                        end
                    end
                end
                S_ADD: begin
                    // Step the moved axis and set up the table scan.
                    if (axis_x) begin
                        r_pos_x <= r_pos_x +
                                   {{(POS_W-SPEED_W){r_speed_x[SPEED_W-1]}}, r_speed_x};
                    end else begin
                        r_pos_y <= r_pos_y +
                                   {{(POS_W-SPEED_W){r_speed_y[SPEED_W-1]}}, r_speed_y};
                    end
                    r_limit <= limit_calc;
                    r_issue <= '0;
                    r_pend  <= 1'b0;
                    r_found <= 1'b0;
                    r_fin   <= (limit_calc == '0);
                end
                S_SCAN: begin
                    if (r_fin) begin
                        // Apply the pushback from the last overlapping entry.
                        r_fin <= 1'b0;
                        r_hit <= r_found;
                        if (r_found) begin
                            if (axis_x) begin
                                r_pos_x <= push_pos;
                            end else begin
                                r_pos_y <= push_pos;
                            end
                        end
                    end else begin
                        // Issue one read a cycle, compare the returned data in the next cycle.
                        if (r_issue < r_limit) begin
                            r_issue <= r_issue + 1'b1;
                            r_pend  <= 1'b1;
                        end else begin
                            r_pend  <= 1'b0;
                        end
                        if (r_pend && overlap) begin
                            r_found <= 1'b1;
                        end
                        if (r_pend && (r_issue == r_limit)) begin
                            r_fin <= 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    r_pend <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Latest overlapping rectangle edges for the moved axis.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && !r_fin && r_pend && overlap) begin
            r_edge_near <= axis_x ? rd_rect.left  : rd_rect.top;
            r_edge_far  <= axis_x ? rd_rect.right : rd_rect.bottom;
        end
    end

    // Result word.
    assign o_strobe    = (r_state == S_DONE);
    assign o_pos_x_out = r_pos_x;
    assign o_pos_y_out = r_pos_y;
    assign o_hit       = r_hit;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted word");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_hit_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_hit) |-> (r_op == OP_MOVE_X || r_op == OP_MOVE_Y))
        else $error("hit reported for a word that is not a move");

    a_reset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_op == OP_RESET) |-> (o_pos_x_out == '0 && o_pos_y_out == '0))
        else $error("reset-position word did not clear the position");

    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !accept) |=> ($stable(r_pos_x) && $stable(r_pos_y)))
        else $error("position changed while idle");
`endif

endmodule

`default_nettype wire

// File: rtl/bcp_rect_mem.sv
// Obstacle rectangle table: one write port, one registered read port.
// Depends on bcp_pkg for the rectangle type.
`default_nettype none

module bcp_rect_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire  [AW-1:0]       i_waddr,
    input  bcp_pkg::t_rect      i_wdata,
    input  wire  [AW-1:0]       i_raddr,
    output bcp_pkg::t_rect      o_rdata
);
    import bcp_pkg::*;

    t_rect r_mem [DEPTH];
    t_rect r_rdata;

    // Write on load items.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read for the scan.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/bcp_overlap_unit.sv
// Shared strict-overlap test of the box against one rectangle.
// Depends on bcp_pkg for the rectangle type and widths.
`default_nettype none

module bcp_overlap_unit (
    input  wire signed [bcp_pkg::POS_W-1:0]  i_pos_x,
    input  wire signed [bcp_pkg::POS_W-1:0]  i_pos_y,
    input  wire        [bcp_pkg::SIZE_W-1:0] i_width,
    input  wire        [bcp_pkg::SIZE_W-1:0] i_height,
    input  bcp_pkg::t_rect                   i_rect,
    output logic                             o_overlap
);
    import bcp_pkg::*;

    localparam int EXT_W = POS_W + 2;

    logic signed [EXT_W-1:0] far_x;
    logic signed [EXT_W-1:0] far_y;
    logic signed [EXT_W-1:0] left_ext;
    logic signed [EXT_W-1:0] top_ext;

    // Box far edges, exact with no wrap.
    always_comb begin
        far_x    = {{2{i_pos_x[POS_W-1]}}, i_pos_x} +
                   $signed({{(EXT_W-SIZE_W){1'b0}}, i_width});
        far_y    = {{2{i_pos_y[POS_W-1]}}, i_pos_y} +
                   $signed({{(EXT_W-SIZE_W){1'b0}}, i_height});
        left_ext = {{2{i_rect.left[POS_W-1]}}, i_rect.left};
        top_ext  = {{2{i_rect.top[POS_W-1]}}, i_rect.top};
    end

    // All four sides are strict.
    assign o_overlap = (far_x > left_ext) && (i_pos_x < i_rect.right) &&
                       (far_y > top_ext) && (i_pos_y < i_rect.bottom);

endmodule

`default_nettype wire

// File: verif/tb_box_collision_pushback_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for box_collision_pushback_unit: an internal box-motion
// predictor checks every result word against the block's output ports.
// Depends on bcp_pkg and the RTL in rtl/ only.

module tb_box_collision_pushback_unit;
    import bcp_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int CLK_HALF = 10;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;
    localparam int WORDS_PER_PHASE = 310;
    // First register index past the defined ones; writes to it must be ignored.
    localparam t_cfg_idx CFG_SPARE = CFG_RECT_COUNT + 3'd1;

    // One command word as driven on the input ports.
    typedef struct packed {
        t_op                op;
        logic [SLOT_W-1:0]  slot;
        t_rect              rect;
        logic               dir;
    } t_cmd_word;

    // One result word as expected on the output ports.
    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             hit;
    } t_box_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_operation;
    logic [SLOT_W-1:0]   i_rect_index;
    logic [POS_W-1:0]    i_rect_left;
    logic [POS_W-1:0]    i_rect_right;
    logic [POS_W-1:0]    i_rect_top;
    logic [POS_W-1:0]    i_rect_bottom;
    logic                i_move_dir;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                o_strobe;
    logic [POS_W-1:0]    o_pos_x_out;
    logic [POS_W-1:0]    o_pos_y_out;
    logic                o_hit;

    // Predictor state: obstacle table, box position and register copies.
    t_rect               obstacle_table [TABLE_DEPTH];
    logic [POS_W-1:0]    box_x;
    logic [POS_W-1:0]    box_y;
    logic [SIZE_W-1:0]   box_w;
    logic [SIZE_W-1:0]   box_h;
    logic [SPEED_W-1:0]  step_x;
    logic [SPEED_W-1:0]  step_y;
    logic [COUNT_W-1:0]  active_rects;

    t_box_result         expected_positions [$];
    t_box_result         oldest_position;
    int                  sender_idle_pct;
    int                  words_sent;
    int                  results_seen;
    int                  pushbacks_seen;
    int                  mismatch_count;
    int                  cycle_count;

    box_collision_pushback_unit #(
        .MAX_RECTS(TABLE_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_rect_index  (i_rect_index),
        .i_rect_left   (i_rect_left),
        .i_rect_right  (i_rect_right),
        .i_rect_top    (i_rect_top),
        .i_rect_bottom (i_rect_bottom),
        .i_move_dir    (i_move_dir),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_pos_x_out   (o_pos_x_out),
        .o_pos_y_out   (o_pos_y_out),
        .o_hit         (o_hit)
    );

    // Free-running clock, 20 ns period.
    always begin
        i_clk = 1'b0;
        #(CLK_HALF);
        i_clk = 1'b1;
        #(CLK_HALF);
    end

    // Returns the last active table entry that strictly overlaps the box, or -1.
    // Comparisons are done in full integer width so nothing wraps here.
    function automatic int last_overlap();
        int px;
        int py;
        int n;
        int found;
        found = -1;
        px = int'($signed(box_x));
        py = int'($signed(box_y));
        n = (active_rects > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_rects);
        for (int i = 0; i < n; i++) begin
            if (px + int'(box_w) > int'($signed(obstacle_table[i].left)) &&
                px < int'($signed(obstacle_table[i].right)) &&
                py + int'(box_h) > int'($signed(obstacle_table[i].top)) &&
                py < int'($signed(obstacle_table[i].bottom))) begin
                found = i;
            end
        end
        return found;
    endfunction

    // Applies one accepted word to the predictor and returns its result word.
    function automatic t_box_result advance_box_model(input t_cmd_word cmd);
        t_box_result res;
        int k;
        logic [31:0] pushed;
        res.hit = 1'b0;
        case (cmd.op)
            OP_LOAD: begin
                obstacle_table[cmd.slot] = cmd.rect;
            end
            OP_MOVE_X: begin
                box_x = box_x + {{(POS_W-SPEED_W){step_x[SPEED_W-1]}}, step_x};
                k = last_overlap();
                if (k >= 0) begin
                    res.hit = 1'b1;
                    if (cmd.dir == 1'b0) begin
                        pushed = int'($signed(obstacle_table[k].left)) - int'(box_w);
                        box_x = pushed[POS_W-1:0];
                    end else begin
                        box_x = obstacle_table[k].right;
                    end
                end
            end
            OP_MOVE_Y: begin
                box_y = box_y + {{(POS_W-SPEED_W){step_y[SPEED_W-1]}}, step_y};
                k = last_overlap();
                if (k >= 0) begin
                    res.hit = 1'b1;
                    if (cmd.dir == 1'b0) begin
                        pushed = int'($signed(obstacle_table[k].top)) - int'(box_h);
                        box_y = pushed[POS_W-1:0];
                    end else begin
                        box_y = obstacle_table[k].bottom;
                    end
                end
            end
            default: begin
                box_x = '0;
                box_y = '0;
            end
        endcase
        res.x = box_x;
        res.y = box_y;
        return res;
    endfunction

    // A word of the given operation with every other field random.
    function automatic t_cmd_word noise_word(input t_op op);
        t_cmd_word cmd;
        cmd.op = op;
        cmd.slot = SLOT_W'($urandom_range(TABLE_DEPTH - 1));
        cmd.rect = {$urandom, $urandom};
        cmd.dir = 1'($urandom_range(1));
        return cmd;
    endfunction

    // A rectangle placed around the current box so that moves tend to collide.
    function automatic t_rect near_rect();
        t_rect r;
        int lx;
        int ty;
        logic [31:0] a;
        logic [31:0] b;
        lx = int'($signed(box_x)) - int'(box_w) - 200 +
             int'($urandom_range(int'(box_w) + 400));
        ty = int'($signed(box_y)) - int'(box_h) - 200 +
             int'($urandom_range(int'(box_h) + 400));
        a = lx;
        b = lx + int'($urandom_range(500));
        r.left = a[POS_W-1:0];
        r.right = b[POS_W-1:0];
        a = ty;
        b = ty + int'($urandom_range(500));
        r.top = a[POS_W-1:0];
        r.bottom = b[POS_W-1:0];
        return r;
    endfunction

    // Sends one word: optional idle cycles, then hold start until accepted.
    task automatic send_word(input t_cmd_word cmd);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        i_operation = cmd.op;
        i_rect_index = cmd.slot;
        i_rect_left = cmd.rect.left;
        i_rect_right = cmd.rect.right;
        i_rect_top = cmd.rect.top;
        i_rect_bottom = cmd.rect.bottom;
        i_move_dir = cmd.dir;
        start = 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_positions.push_back(advance_box_model(cmd));
        words_sent++;
    endtask

    // Drops start and waits until the block is idle with nothing outstanding.
    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (busy || expected_positions.size() != 0) @(negedge i_clk);
    endtask

    // Writes one register while the block is idle and mirrors it in the predictor.
    task automatic write_register(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        wait_idle();
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            CFG_OBJECT_WIDTH:  box_w = data[SIZE_W-1:0];
            CFG_OBJECT_HEIGHT: box_h = data[SIZE_W-1:0];
            CFG_SPEED_X:       step_x = data[SPEED_W-1:0];
            CFG_SPEED_Y:       step_y = data[SPEED_W-1:0];
            CFG_RECT_COUNT:    active_rects = data[COUNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Writes all five registers; unused upper data bits carry random noise.
    task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                             input logic [SPEED_W-1:0] sx, input logic [SPEED_W-1:0] sy,
                             input logic [COUNT_W-1:0] n);
        logic [31:0] pad;
        pad = $urandom;
        write_register(CFG_OBJECT_WIDTH, w);
        write_register(CFG_OBJECT_HEIGHT, h);
        write_register(CFG_SPEED_X, {pad[0], sx});
        write_register(CFG_SPEED_Y, {pad[1], sy});
        write_register(CFG_RECT_COUNT, {pad[8:2], n});
    endtask

    // Fills every table slot, then checks each pushback direction at the extremes.
    task automatic test_table_and_pushback();
        t_cmd_word cmd;
        sender_idle_pct = 0;
        for (int slot = 0; slot < TABLE_DEPTH; slot++) begin
            cmd = noise_word(OP_LOAD);
            cmd.slot = SLOT_W'(slot);
            if (slot == 0) begin
                // Whole plane: overlaps every box but one at an edge of the range.
                cmd.rect = {16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
            end else if (slot == 1) begin
                // Inverted edges can never overlap.
                cmd.rect = {16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000};
            end else if (slot == 2) begin
                cmd.rect = {16'sd100, 16'sd200, 16'sd100, 16'sd200};
            end
            send_word(cmd);
        end

        // Largest box and speeds; only the whole-plane entry is active.
        configure(12'hFFF, 12'hFFF, 11'h3FF, 11'h400, 5'd1);
        write_register(CFG_SPARE, 12'($urandom));
        cmd = noise_word(OP_MOVE_X);
        cmd.dir = 1'b0;
        send_word(cmd);
        cmd = noise_word(OP_MOVE_Y);
        cmd.dir = 1'b0;
        send_word(cmd);
        cmd = noise_word(OP_MOVE_X);
        cmd.dir = 1'b1;
        send_word(cmd);
        cmd = noise_word(OP_MOVE_Y);
        cmd.dir = 1'b1;
        send_word(cmd);

        // No active entries: the x move wraps past the top of the range.
        configure(12'hFFF, 12'hFFF, 11'h3FF, 11'h400, 5'd0);
        send_word(noise_word(OP_MOVE_X));
        send_word(noise_word(OP_RESET));
        send_word(noise_word(OP_MOVE_Y));

        // Zero-size box, zero speed, count above the table size saturates.
        configure(12'h000, 12'h000, 11'h000, 11'h000, 5'd31);
        cmd = noise_word(OP_MOVE_X);
        cmd.dir = 1'b1;
        send_word(cmd);
        cmd = noise_word(OP_MOVE_Y);
        cmd.dir = 1'b0;
        send_word(cmd);
    endtask

    // Random motion: mostly moves near freshly loaded obstacles, some noise loads.
    task automatic test_random_motion(input int idle_pct, input int words);
        t_cmd_word cmd;
        int pick;
        configure(SIZE_W'($urandom), SIZE_W'($urandom), SPEED_W'($urandom),
                  SPEED_W'($urandom), COUNT_W'($urandom_range(31, 1)));
        sender_idle_pct = idle_pct;
        for (int i = 0; i < words; i++) begin
            pick = $urandom_range(99);
            if (pick < 14) begin
                cmd = noise_word(OP_LOAD);
                pick = $urandom_range(9);
                if (pick < 7) begin
                    cmd.rect = near_rect();
                end else if (pick == 7) begin
                    // Near rectangle with swapped horizontal edges.
                    cmd.rect = near_rect();
                    {cmd.rect.left, cmd.rect.right} = {cmd.rect.right, cmd.rect.left};
                end
            end else if (pick < 55) begin
                cmd = noise_word(OP_MOVE_X);
            end else if (pick < 96) begin
                cmd = noise_word(OP_MOVE_Y);
            end else begin
                cmd = noise_word(OP_RESET);
            end
            send_word(cmd);
        end
    endtask

    // Result checker: each strobed word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (expected_positions.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected result word: x=%0d y=%0d hit=%0b",
                             $signed(o_pos_x_out), $signed(o_pos_y_out), o_hit);
            end else begin
                oldest_position = expected_positions.pop_front();
                if (oldest_position.hit)
                    pushbacks_seen++;
                if (o_pos_x_out !== oldest_position.x || o_pos_y_out !== oldest_position.y ||
                    o_hit !== oldest_position.hit) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"Mismatch on result %0d: expected x=%0d y=%0d hit=%0b,",
                                  " got x=%0d y=%0d hit=%0b"},
                                 results_seen, $signed(oldest_position.x),
                                 $signed(oldest_position.y), oldest_position.hit,
                                 $signed(o_pos_x_out), $signed(o_pos_y_out), o_hit);
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_positions.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = OP_LOAD;
        i_rect_index = '0;
        i_rect_left = '0;
        i_rect_right = '0;
        i_rect_top = '0;
        i_rect_bottom = '0;
        i_move_dir = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_OBJECT_WIDTH;
        i_cfg_data = '0;
        box_x = '0;
        box_y = '0;
        box_w = '0;
        box_h = '0;
        step_x = '0;
        step_y = '0;
        active_rects = '0;
        sender_idle_pct = 0;
        words_sent = 0;
        results_seen = 0;
        pushbacks_seen = 0;
        mismatch_count = 0;
        cycle_count = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            obstacle_table[i] = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_table_and_pushback();
        test_random_motion(0, WORDS_PER_PHASE);
        test_random_motion(88, WORDS_PER_PHASE);
        // The result side cannot stall, so this phase runs without idling.
        test_random_motion(0, WORDS_PER_PHASE);
        test_random_motion(38, WORDS_PER_PHASE);

        // Drain outstanding results, then watch for stray words.
        @(negedge i_clk);
        start = 1'b0;
        while (expected_positions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d command words: directed table fill and pushbacks, then random",
                 words_sent);
        $display({"motion with sender idle rates of 0, 88 and 38 percent;",
                  " %0d results, %0d pushbacks, %0d mismatches."},
                 results_seen, pushbacks_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/bcp_pkg.sv
rtl/bcp_rect_mem.sv
rtl/bcp_overlap_unit.sv
rtl/box_collision_pushback_unit.sv
verif/tb_box_collision_pushback_unit.sv
